// File: hw/rtl/sphere_triangle_contact_macros.svh
// ----------------------------------------------------------------------------
// sphere_triangle_contact_macros.svh
// Assertion helpers for the sphere/triangle contact block.
// ----------------------------------------------------------------------------
`ifndef SPHERE_TRIANGLE_CONTACT_MACROS_SVH
`define SPHERE_TRIANGLE_CONTACT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define STC_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define STC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/stc_pkg.sv
// ----------------------------------------------------------------------------
// stc_pkg
// Widths, stage records and step functions of the sphere/triangle contact pipe.
// ----------------------------------------------------------------------------
package stc_pkg;

  localparam int COORD_BITS = 21;
  localparam int FRAC_BITS  = 10;

  localparam int CW    = COORD_BITS;           // one coordinate
  localparam int VW    = 3 * CW;               // packed vector
  localparam int RAD_W = 20;                   // radius and depth
  localparam int EW    = CW + 1;               // vertex difference
  localparam int DS_W  = EW + CW + 2;          // dot(w, n)
  localparam int D_W   = DS_W - FRAC_BITS;     // plane distance
  localparam int XR_W  = EW + CW + 1;          // raw cross component
  localparam int CR_W  = XR_W - FRAC_BITS;     // scaled cross component
  localparam int ID_W  = CR_W + EW + 2;        // edge plane test dot
  localparam int NUM_W = 2 * EW + 2;           // edge projection dots
  localparam int REM_W = NUM_W + 1;            // edge divider remainder
  localparam int ND_W  = CW + D_W;             // n * d
  localparam int T_W   = FRAC_BITS + 1;        // clamped edge parameter
  localparam int TE_W  = T_W + 1 + EW;         // t * e
  localparam int QW    = EW + 2;               // point on edge
  localparam int WQ_W  = QW + 1;               // center minus edge point
  localparam int D2_W  = 2 * WQ_W + 2;         // squared distance
  localparam int RR_W  = 2 * RAD_W;            // r * r
  localparam int RS_W  = RAD_W + 2;            // root remainder
  localparam int NR_W  = RAD_W + 1;            // normal divider remainder
  localparam int NQ_W  = FRAC_BITS + 1;        // normal quotient

  localparam int SAT_A = ND_W - FRAC_BITS + 1;
  localparam int SAT_B = (QW > NQ_W + 1) ? QW : NQ_W + 1;
  localparam int SAT_W = (SAT_A > SAT_B) ? SAT_A : SAT_B;

  localparam logic [T_W-1:0] T_ONE = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic signed [SAT_W-1:0] C_MAX = (SAT_W'(1) <<< (CW - 1)) - SAT_W'(1);
  localparam logic signed [SAT_W-1:0] C_MIN = -(SAT_W'(1) <<< (CW - 1));

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [EW-1:0] diff_t;

  typedef struct {
    coord_t             c [3];
    coord_t             n [3];
    coord_t             v [3][3];
    diff_t              e [3][3];
    diff_t              w [3][3];
    logic [RAD_W-1:0]   r;
    logic [VW-1:0]      n_raw;
  } s1_t;

  typedef struct {
    coord_t                    c [3];
    coord_t                    n [3];
    coord_t                    v [3][3];
    diff_t                     e [3][3];
    diff_t                     w [3][3];
    logic [RAD_W-1:0]          r;
    logic [VW-1:0]             n_raw;
    logic signed [DS_W-1:0]    dsum;
    logic signed [XR_W-1:0]    xr [3][3];
    logic signed [NUM_W-1:0]   num [3];
    logic signed [NUM_W-1:0]   den [3];
  } s2_t;

  typedef struct {
    coord_t                    c [3];
    coord_t                    v [3][3];
    diff_t                     e [3][3];
    logic [RAD_W-1:0]          r;
    logic [VW-1:0]             n_raw;
    logic signed [NUM_W-1:0]   num [3];
    logic signed [NUM_W-1:0]   den [3];
    logic [D_W-1:0]            ad;
    logic signed [ND_W-1:0]    nd [3];
    logic                      in_planes;
  } s3_t;

  // Face result, settled early and carried to the end.
  typedef struct {
    logic [VW-1:0]      n_raw;
    logic [RAD_W-1:0]   r;
    logic               face;
    logic [VW-1:0]      face_pt;
    logic [RAD_W-1:0]   face_pen;
  } base_t;

  typedef struct {
    base_t                 b;
    coord_t                c [3];
    coord_t                v [3][3];
    diff_t                 e [3][3];
    logic [NUM_W-1:0]      den [3];
    logic [REM_W-1:0]      rem [3];
    logic [FRAC_BITS-1:0]  quo [3];
    logic                  fix [3];
    logic                  one [3];
  } bd_t;

  typedef struct {
    base_t                    b;
    logic signed [QW-1:0]     q [3][3];
    logic signed [WQ_W-1:0]   wq [3][3];
  } q1_t;

  typedef struct {
    base_t                    b;
    logic signed [QW-1:0]     q [3][3];
    logic signed [WQ_W-1:0]   wq [3][3];
    logic [D2_W-1:0]          d2 [3];
    logic [RR_W-1:0]          rr;
  } q2_t;

  typedef struct {
    base_t                    b;
    logic                     hit;
    logic [VW-1:0]            bq_pk;
    logic signed [WQ_W-1:0]   bw [3];
  } ctx2_t;

  typedef struct {
    ctx2_t              x;
    logic [RR_W-1:0]    rad;
    logic [RS_W-1:0]    rem;
    logic [RAD_W-1:0]   root;
  } sr_t;

  typedef struct {
    ctx2_t              x;
    logic [RAD_W-1:0]   len;
    logic [NR_W-1:0]    rem [3];
    logic [NQ_W-1:0]    quo [3];
  } nd_t;

  function automatic coord_t cget(logic [VW-1:0] w, int k);
    return coord_t'(w[k*CW +: CW]);
  endfunction

  function automatic int nxt(int i);
    return (i == 2) ? 0 : i + 1;
  endfunction

  function automatic coord_t sat(logic signed [SAT_W-1:0] x);
    if (x > C_MAX) return coord_t'(C_MAX);
    if (x < C_MIN) return coord_t'(C_MIN);
    return coord_t'(x);
  endfunction

  function automatic logic [VW-1:0] pack3(coord_t x0, coord_t x1, coord_t x2);
    return {x2, x1, x0};
  endfunction

  // One quotient bit of num * 2^F / den for each edge.
  function automatic bd_t tdiv_step(bd_t s);
    bd_t              o;
    logic [REM_W-1:0] r2;
    o = s;
    for (int i = 0; i < 3; i++) begin
      r2 = s.rem[i] << 1;
      if (r2 >= REM_W'(s.den[i])) begin
        o.rem[i] = r2 - REM_W'(s.den[i]);
        o.quo[i] = {s.quo[i][FRAC_BITS-2:0], 1'b1};
      end else begin
        o.rem[i] = r2;
        o.quo[i] = {s.quo[i][FRAC_BITS-2:0], 1'b0};
      end
    end
    return o;
  endfunction

  // One root bit of the floor square root.
  function automatic sr_t sqrt_step(sr_t s);
    sr_t               o;
    logic [RS_W+1:0]   r2;
    logic [RS_W+1:0]   trial;
    o     = s;
    r2    = {s.rem, s.rad[RR_W-1 -: 2]};
    trial = (RS_W + 2)'({s.root, 2'b01});
    o.rad = s.rad << 2;
    if (r2 >= trial) begin
      o.rem  = RS_W'(r2 - trial);
      o.root = {s.root[RAD_W-2:0], 1'b1};
    end else begin
      o.rem  = RS_W'(r2);
      o.root = {s.root[RAD_W-2:0], 1'b0};
    end
    return o;
  endfunction

  // Integer bit of |w| / len; the remainder is below 2*len after it.
  function automatic nd_t ndiv_first(sr_t s);
    nd_t                     o;
    logic [WQ_W-1:0]         a;
    logic [NR_W-1:0]         an;
    o.x   = s.x;
    o.len = s.root;
    for (int k = 0; k < 3; k++) begin
      a  = (s.x.bw[k] < 0) ? WQ_W'(-s.x.bw[k]) : WQ_W'(s.x.bw[k]);
      an = NR_W'(a);
      if (an >= NR_W'(s.root)) begin
        o.rem[k] = an - NR_W'(s.root);
        o.quo[k] = NQ_W'(1);
      end else begin
        o.rem[k] = an;
        o.quo[k] = '0;
      end
    end
    return o;
  endfunction

  // One fraction bit of |w| * 2^F / len.
  function automatic nd_t ndiv_step(nd_t s);
    nd_t             o;
    logic [NR_W-1:0] r2;
    o = s;
    for (int k = 0; k < 3; k++) begin
      r2 = s.rem[k] << 1;
      if (r2 >= NR_W'(s.len)) begin
        o.rem[k] = r2 - NR_W'(s.len);
        o.quo[k] = {s.quo[k][NQ_W-2:0], 1'b1};
      end else begin
        o.rem[k] = r2;
        o.quo[k] = {s.quo[k][NQ_W-2:0], 1'b0};
      end
    end
    return o;
  endfunction

endpackage

// File: hw/rtl/stc_if.sv
// ----------------------------------------------------------------------------
// stc_in_if / stc_out_if
// Valid/ready channels carrying one sphere/triangle pair and one contact.
// ----------------------------------------------------------------------------
interface stc_in_if import stc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VW-1:0]    sphere_center;
  logic [RAD_W-1:0] sphere_radius;
  logic [VW-1:0]    vertex_a;
  logic [VW-1:0]    vertex_b;
  logic [VW-1:0]    vertex_c;
  logic [VW-1:0]    face_normal;

  modport source (output valid, sphere_center, sphere_radius, vertex_a, vertex_b,
                  vertex_c, face_normal, input ready);
  modport sink   (input valid, sphere_center, sphere_radius, vertex_a, vertex_b,
                  vertex_c, face_normal, output ready);
endinterface

interface stc_out_if import stc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             hit;
  logic [VW-1:0]    contact_point;
  logic [VW-1:0]    contact_normal;
  logic [RAD_W-1:0] penetration;

  modport source (output valid, hit, contact_point, contact_normal, penetration,
                  input ready);
  modport sink   (input valid, hit, contact_point, contact_normal, penetration,
                  output ready);
endinterface

// File: hw/rtl/sphere_triangle_contact.sv
// ----------------------------------------------------------------------------
// sphere_triangle_contact
// Sphere against triangle contact test: face contact or nearest clamped edge.
//
// Takes one sphere/triangle pair per cycle while the output is not stalled
// and returns one contact item per pair, in order. The pipeline depth
// comes from three bit-serial units laid out as pipeline stages: the edge
// parameter divider (FRAC_BITS steps), the floor square root of the winning
// squared distance (20 steps, one per root bit) and the contact normal
// divider (FRAC_BITS + 1 steps). All stages advance together; a stalled
// output holds the whole pipe and the input is not ready. A miss returns
// all fields zero.
// ----------------------------------------------------------------------------
`include "sphere_triangle_contact_macros.svh"

module sphere_triangle_contact import stc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  stc_in_if.sink    pair,
  stc_out_if.source contact
);

  logic adv;

  s1_t   s1, s1_next;
  s2_t   s2, s2_next;
  s3_t   s3, s3_next;
  bd_t   bd [FRAC_BITS+1];
  bd_t   bd_next;
  q1_t   q1, q1_next;
  q2_t   q2, q2_next;
  sr_t   sr [RAD_W+1];
  sr_t   sr_next;
  nd_t   nd [FRAC_BITS+1];

  logic                 v1, v2, v3, q1v, q2v;
  logic [FRAC_BITS:0]   bdv;
  logic [RAD_W:0]       srv;
  logic [FRAC_BITS:0]   ndv;

  logic             res_valid, res_hit;
  logic [VW-1:0]    res_point, res_normal;
  logic [RAD_W-1:0] res_pen;
  logic             hit_next;
  logic [VW-1:0]    point_next, normal_next;
  logic [RAD_W-1:0] pen_next;

  assign adv        = !res_valid || contact.ready;
  assign pair.ready = adv;

  // Unpack and form edges and center offsets.
  always_comb begin
    s1_next.r     = pair.sphere_radius;
    s1_next.n_raw = pair.face_normal;
    for (int k = 0; k < 3; k++) begin
      s1_next.c[k]    = cget(pair.sphere_center, k);
      s1_next.n[k]    = cget(pair.face_normal, k);
      s1_next.v[0][k] = cget(pair.vertex_a, k);
      s1_next.v[1][k] = cget(pair.vertex_b, k);
      s1_next.v[2][k] = cget(pair.vertex_c, k);
    end
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        s1_next.e[i][k] = diff_t'(s1_next.v[nxt(i)][k]) - diff_t'(s1_next.v[i][k]);
        s1_next.w[i][k] = diff_t'(s1_next.c[k]) - diff_t'(s1_next.v[i][k]);
      end
    end
  end

  // Plane distance, edge normals, projection dots.
  always_comb begin
    s2_next.c     = s1.c;
    s2_next.n     = s1.n;
    s2_next.v     = s1.v;
    s2_next.e     = s1.e;
    s2_next.w     = s1.w;
    s2_next.r     = s1.r;
    s2_next.n_raw = s1.n_raw;
    s2_next.dsum  = '0;
    for (int k = 0; k < 3; k++)
      s2_next.dsum = s2_next.dsum + DS_W'(s1.w[0][k]) * DS_W'(s1.n[k]);
    for (int i = 0; i < 3; i++) begin
      s2_next.xr[i][0] = XR_W'(s1.e[i][1]) * XR_W'(s1.n[2])
                       - XR_W'(s1.e[i][2]) * XR_W'(s1.n[1]);
      s2_next.xr[i][1] = XR_W'(s1.e[i][2]) * XR_W'(s1.n[0])
                       - XR_W'(s1.e[i][0]) * XR_W'(s1.n[2]);
      s2_next.xr[i][2] = XR_W'(s1.e[i][0]) * XR_W'(s1.n[1])
                       - XR_W'(s1.e[i][1]) * XR_W'(s1.n[0]);
      s2_next.num[i] = '0;
      s2_next.den[i] = '0;
      for (int k = 0; k < 3; k++) begin
        s2_next.num[i] = s2_next.num[i] + NUM_W'(s1.w[i][k]) * NUM_W'(s1.e[i][k]);
        s2_next.den[i] = s2_next.den[i] + NUM_W'(s1.e[i][k]) * NUM_W'(s1.e[i][k]);
      end
    end
  end

  // Edge plane tests and n * d for the projected point.
  always_comb begin
    logic signed [D_W-1:0]  d;
    logic signed [CR_W-1:0] cr;
    logic signed [ID_W-1:0] idot;
    d                 = D_W'(s2.dsum >>> FRAC_BITS);
    s3_next.c         = s2.c;
    s3_next.v         = s2.v;
    s3_next.e         = s2.e;
    s3_next.r         = s2.r;
    s3_next.n_raw     = s2.n_raw;
    s3_next.num       = s2.num;
    s3_next.den       = s2.den;
    s3_next.ad        = d[D_W-1] ? D_W'(-d) : D_W'(d);
    s3_next.in_planes = 1'b1;
    for (int k = 0; k < 3; k++)
      s3_next.nd[k] = ND_W'(d) * ND_W'(s2.n[k]);
    for (int i = 0; i < 3; i++) begin
      idot = '0;
      for (int k = 0; k < 3; k++) begin
        cr   = CR_W'(s2.xr[i][k] >>> FRAC_BITS);
        idot = idot + ID_W'(cr) * ID_W'(s2.w[i][k]);
      end
      if (idot > 0)
        s3_next.in_planes = 1'b0;
    end
  end

  // Settle the face result; set up the edge dividers.
  always_comb begin
    coord_t pf [3];
    logic   zero_t;
    logic   big;
    for (int k = 0; k < 3; k++)
      pf[k] = sat(SAT_W'(s3.c[k]) - SAT_W'(s3.nd[k] >>> FRAC_BITS));
    bd_next.c          = s3.c;
    bd_next.v          = s3.v;
    bd_next.e          = s3.e;
    bd_next.b.r        = s3.r;
    bd_next.b.n_raw    = s3.n_raw;
    bd_next.b.face     = s3.in_planes &&
                         ({{D_W{1'b0}}, s3.r} > {{RAD_W{1'b0}}, s3.ad});
    bd_next.b.face_pen = s3.r - RAD_W'(s3.ad);
    bd_next.b.face_pt  = pack3(pf[0], pf[1], pf[2]);
    for (int i = 0; i < 3; i++) begin
      zero_t         = (s3.den[i] == '0) || (s3.num[i] <= 0);
      big            = s3.num[i] >= s3.den[i];
      bd_next.fix[i] = zero_t || big;
      bd_next.one[i] = !zero_t && big;
      bd_next.den[i] = NUM_W'(s3.den[i]);
      bd_next.rem[i] = (zero_t || big) ? '0 : REM_W'(s3.num[i]);
      bd_next.quo[i] = '0;
    end
  end

  // Clamped point on each edge and its offset from the center.
  always_comb begin
    logic [T_W-1:0]          t;
    logic signed [TE_W-1:0]  te;
    q1_next.b = bd[FRAC_BITS].b;
    for (int i = 0; i < 3; i++) begin
      if (bd[FRAC_BITS].fix[i])
        t = bd[FRAC_BITS].one[i] ? T_ONE : '0;
      else
        t = T_W'(bd[FRAC_BITS].quo[i]);
      for (int k = 0; k < 3; k++) begin
        te = TE_W'($signed({1'b0, t})) * TE_W'(bd[FRAC_BITS].e[i][k]);
        q1_next.q[i][k]  = QW'(bd[FRAC_BITS].v[i][k]) + QW'(te >>> FRAC_BITS);
        q1_next.wq[i][k] = WQ_W'(bd[FRAC_BITS].c[k]) - WQ_W'(q1_next.q[i][k]);
      end
    end
  end

  // Squared distances and r * r.
  always_comb begin
    logic signed [D2_W-1:0] acc;
    q2_next.b  = q1.b;
    q2_next.q  = q1.q;
    q2_next.wq = q1.wq;
    q2_next.rr = RR_W'(q1.b.r) * RR_W'(q1.b.r);
    for (int i = 0; i < 3; i++) begin
      acc = '0;
      for (int k = 0; k < 3; k++)
        acc = acc + D2_W'(q1.wq[i][k]) * D2_W'(q1.wq[i][k]);
      q2_next.d2[i] = D2_W'(acc);
    end
  end

  // Pick the nearest edge point; earlier edge wins a tie.
  always_comb begin
    logic [1:0]      bi;
    logic [D2_W-1:0] bd2;
    coord_t          pq [3];
    bi  = 2'd0;
    bd2 = q2.d2[0];
    if (q2.d2[1] < bd2) begin
      bi  = 2'd1;
      bd2 = q2.d2[1];
    end
    if (q2.d2[2] < bd2) begin
      bi  = 2'd2;
      bd2 = q2.d2[2];
    end
    for (int k = 0; k < 3; k++) begin
      pq[k]          = sat(SAT_W'(q2.q[bi][k]));
      sr_next.x.bw[k] = q2.wq[bi][k];
    end
    sr_next.x.b     = q2.b;
    sr_next.x.hit   = {{RR_W{1'b0}}, bd2} <= {{D2_W{1'b0}}, q2.rr};
    sr_next.x.bq_pk = pack3(pq[0], pq[1], pq[2]);
    sr_next.rad     = RR_W'(bd2);
    sr_next.rem     = '0;
    sr_next.root    = '0;
  end

  // Final selection of the contact.
  always_comb begin
    coord_t                   nv [3];
    logic signed [NQ_W:0]     nq;
    logic signed [NQ_W:0]     sv;
    for (int k = 0; k < 3; k++) begin
      nq    = $signed({1'b0, nd[FRAC_BITS].quo[k]});
      sv    = (nd[FRAC_BITS].x.bw[k] < 0) ? -nq : nq;
      nv[k] = sat(SAT_W'(sv));
    end
    priority if (nd[FRAC_BITS].x.b.face) begin
      hit_next    = 1'b1;
      point_next  = nd[FRAC_BITS].x.b.face_pt;
      normal_next = nd[FRAC_BITS].x.b.n_raw;
      pen_next    = nd[FRAC_BITS].x.b.face_pen;
    end else if (nd[FRAC_BITS].x.hit) begin
      hit_next    = 1'b1;
      point_next  = nd[FRAC_BITS].x.bq_pk;
      normal_next = (nd[FRAC_BITS].len == '0) ? nd[FRAC_BITS].x.b.n_raw
                                              : pack3(nv[0], nv[1], nv[2]);
      pen_next    = nd[FRAC_BITS].x.b.r - nd[FRAC_BITS].len;
    end else begin
      hit_next    = 1'b0;
      point_next  = '0;
      normal_next = '0;
      pen_next    = '0;
    end
  end

  // Datapath: advance everything together, hold on stall.
  always_ff @(posedge clk) begin
    if (adv) begin
      s1    <= s1_next;
      s2    <= s2_next;
      s3    <= s3_next;
      bd[0] <= bd_next;
      for (int j = 1; j <= FRAC_BITS; j++)
        bd[j] <= tdiv_step(bd[j-1]);
      q1    <= q1_next;
      q2    <= q2_next;
      sr[0] <= sr_next;
      for (int j = 1; j <= RAD_W; j++)
        sr[j] <= sqrt_step(sr[j-1]);
      nd[0] <= ndiv_first(sr[RAD_W]);
      for (int j = 1; j <= FRAC_BITS; j++)
        nd[j] <= ndiv_step(nd[j-1]);
      res_hit    <= hit_next;
      res_point  <= point_next;
      res_normal <= normal_next;
      res_pen    <= pen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      bdv       <= '0;
      q1v       <= 1'b0;
      q2v       <= 1'b0;
      srv       <= '0;
      ndv       <= '0;
      res_valid <= 1'b0;
    end else if (adv) begin
      v1        <= pair.valid;
      v2        <= v1;
      v3        <= v2;
      bdv       <= {bdv[FRAC_BITS-1:0], v3};
      q1v       <= bdv[FRAC_BITS];
      q2v       <= q1v;
      srv       <= {srv[RAD_W-1:0], q2v};
      ndv       <= {ndv[FRAC_BITS-1:0], srv[RAD_W]};
      res_valid <= ndv[FRAC_BITS];
    end
  end

  assign contact.valid          = res_valid;
  assign contact.hit            = res_hit;
  assign contact.contact_point  = res_point;
  assign contact.contact_normal = res_normal;
  assign contact.penetration    = res_pen;

  `STC_ASSERT_NOW(a_stall_blocks_input, contact.valid && !contact.ready, !pair.ready, "item taken during output stall")
  `STC_ASSERT_NOW(a_miss_is_zero, contact.valid && !contact.hit, contact.contact_point == '0 && contact.contact_normal == '0 && contact.penetration == '0, "miss carries nonzero payload")
  `STC_ASSERT_NEXT(a_accept_enters, pair.valid && pair.ready, v1, "accepted item missing from first stage")

endmodule
